// ----- design/log_detector_power_convert_assert.svh -----
// Assertion macros shared by the converter's modules.
// Each macro compiles to nothing when SYNTHESIS is defined.
`ifndef LOG_DETECTOR_POWER_CONVERT_ASSERT_SVH
`define LOG_DETECTOR_POWER_CONVERT_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define LDPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LDPC_ASSERT(lbl, clk, rst_n, prop, msg)

`define LDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/ldpc_pkg.sv -----
package ldpc_pkg;

  // Converter and field widths.
  localparam int ADC_BITS = 12;
  localparam int ADC_W    = 12;
  localparam int CFG_IDX_W = 3;

  // Exponent table: EXP_TABLE_DEPTH steps over one octave, plus the end point.
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
  localparam int ROM_ADDR_BITS   = EXP_IDX_BITS + 1;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point constants.
  localparam int Q16_ONE           = 65536;
  localparam int LOG2_10_DIV10_Q30 = 356689313;
  localparam int LN2_Q30           = 744261118;
  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [31:0] Q16_MAX  = 32'h7FFF_FFFF;
  localparam logic signed [31:0] OVERLOAD_Q16 = 32'(8888 * Q16_ONE);

  // Cubic segment chosen by the breakpoints.
  typedef enum logic [1:0] {
    SEG_LOW  = 2'd0,
    SEG_MID  = 2'd1,
    SEG_HIGH = 2'd2
  } seg_e;

  // Unit reported with each result.
  typedef enum logic [2:0] {
    UNIT_DBM = 3'd0,
    UNIT_W   = 3'd1,
    UNIT_MW  = 3'd2,
    UNIT_UW  = 3'd3,
    UNIT_NW  = 3'd4,
    UNIT_PW  = 3'd5,
    UNIT_OVL = 3'd6
  } unit_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_LOW    = 3'd0,
    CFG_SEG_MID    = 3'd1,
    CFG_SEG_HIGH   = 3'd2,
    CFG_BREAK_LOW  = 3'd3,
    CFG_BREAK_HIGH = 3'd4,
    CFG_OFFSET_DB  = 3'd5,
    CFG_DBM_MODE   = 3'd6
  } cfg_idx_e;

  // Configuration register set.
  typedef struct packed {
    logic [63:0]        seg_low;
    logic [63:0]        seg_mid;
    logic [63:0]        seg_high;
    logic [ADC_W-1:0]   break_low;
    logic [ADC_W-1:0]   break_high;
    logic signed [15:0] offset_db;
    logic               dbm_mode;
  } cfg_t;

  // One classified sample as it travels through the queue.
  typedef struct packed {
    logic [ADC_W-1:0] x;
    seg_e             seg;
  } item_t;

  // Entry i of the exponent table: 2^(i/EXP_TABLE_DEPTH) at Q30, from an
  // integer Taylor series through the 16th-power term. Evaluated at elaboration only.
  function automatic logic [31:0] pow2_entry(int unsigned i);
    logic [63:0] tq;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    int          k;
    tq = (64'(i) * 64'(LN2_Q30) + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (k = 1; k <= 16; k++) begin
      prod = (term * tq) >> 30;
      case (k)
        2:       term = prod / 64'd2;
        3:       term = prod / 64'd3;
        4:       term = prod / 64'd4;
        5:       term = prod / 64'd5;
        6:       term = prod / 64'd6;
        7:       term = prod / 64'd7;
        8:       term = prod / 64'd8;
        9:       term = prod / 64'd9;
        10:      term = prod / 64'd10;
        11:      term = prod / 64'd11;
        12:      term = prod / 64'd12;
        13:      term = prod / 64'd13;
        14:      term = prod / 64'd14;
        15:      term = prod / 64'd15;
        16:      term = prod / 64'd16;
        default: term = prod;
      endcase
      sum = sum + term;
    end
    return sum[31:0];
  endfunction

endpackage

// ----- design/log_detector_power_convert.sv -----
// Throughput: one beat per cycle; the front stage, the four-entry queue and the
// eight-stage arithmetic pipeline each advance every cycle, so busy stays low.
// Reset clears the front stage, the queue and the pipeline valids and loads the
// register defaults; the exponent table is constant logic and needs no clearing pass.
module log_detector_power_convert (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ldpc_pkg::ADC_W-1:0]          adc_code_i,
  output logic                                done_o,
  output logic signed [31:0]                  level_value_o,
  output logic [2:0]                          unit_code_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ldpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);
  import ldpc_pkg::*;

  cfg_t  cfg_q;
  cfg_t  cfg_d;
  logic  push;
  logic  q_full;
  logic  q_empty;
  item_t front_item;
  item_t back_item;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SEG_LOW:    cfg_d.seg_low    = cfg_data_i;
        CFG_SEG_MID:    cfg_d.seg_mid    = cfg_data_i;
        CFG_SEG_HIGH:   cfg_d.seg_high   = cfg_data_i;
        CFG_BREAK_LOW:  cfg_d.break_low  = cfg_data_i[ADC_W-1:0];
        CFG_BREAK_HIGH: cfg_d.break_high = cfg_data_i[ADC_W-1:0];
        CFG_OFFSET_DB:  cfg_d.offset_db  = signed'(cfg_data_i[15:0]);
        CFG_DBM_MODE:   cfg_d.dbm_mode   = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg_low    <= '0;
      cfg_q.seg_mid    <= '0;
      cfg_q.seg_high   <= '0;
      cfg_q.break_low  <= '1;
      cfg_q.break_high <= '1;
      cfg_q.offset_db  <= '0;
      cfg_q.dbm_mode   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept and classify.
  ldpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .adc_code_i (adc_code_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .item_o     (front_item)
  );

  // Queue between the ends; the back end drains it every cycle.
  ldpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .pop_i   (!q_empty),
    .rdata_o (back_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: polynomial and power pipeline.
  ldpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!q_empty),
    .item_i        (back_item),
    .cfg_i         (cfg_q),
    .done_o        (done_o),
    .level_value_o (level_value_o),
    .unit_code_o   (unit_code_o)
  );

endmodule

// ----- design/ldpc_front.sv -----
`include "log_detector_power_convert_assert.svh"

module ldpc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ldpc_pkg::ADC_W-1:0] adc_code_i,
  input  ldpc_pkg::cfg_t            cfg_i,
  input  logic                      q_full_i,
  output logic                      busy_o,
  output logic                      push_o,
  output ldpc_pkg::item_t           item_o
);
  import ldpc_pkg::*;

  localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

  logic             accept;
  logic             valid_q;
  logic             valid_d;
  item_t            item_q;
  item_t            item_d;
  logic [ADC_W-1:0] x;

  // The front stage holds one beat until the queue takes it.
  assign busy_o  = valid_q && q_full_i;
  assign accept  = start_i && !busy_o;
  assign push_o  = valid_q && !q_full_i;
  assign valid_d = accept || (valid_q && !push_o);

  // Mask the sample and pick its cubic segment.
  always_comb begin
    x = adc_code_i & ADC_MASK;
    item_d.x = x;
    if (x < cfg_i.break_low) begin
      item_d.seg = SEG_LOW;
    end else if (x < cfg_i.break_high) begin
      item_d.seg = SEG_MID;
    end else begin
      item_d.seg = SEG_HIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

  `LDPC_ASSERT_NEXT(a_accept_holds, clk_i, rst_ni, accept, valid_q, "accepted beat lost in front stage")
  `LDPC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, valid_q && q_full_i, valid_q && $stable(item_q), "stalled front beat changed")

endmodule

// ----- design/ldpc_queue.sv -----
`include "log_detector_power_convert_assert.svh"

module ldpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ldpc_pkg::item_t wdata_i,
  input  logic            pop_i,
  output ldpc_pkg::item_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import ldpc_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_d;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LDPC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= QCNT_W'(QUEUE_DEPTH), "queue fill count exceeds depth")
  `LDPC_ASSERT_NEXT(a_count_grows, clk_i, rst_ni, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue count did not grow on push")

endmodule

// ----- design/ldpc_back.sv -----
`include "log_detector_power_convert_assert.svh"

module ldpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ldpc_pkg::item_t     item_i,
  input  ldpc_pkg::cfg_t      cfg_i,
  output logic                done_o,
  output logic signed [31:0]  level_value_o,
  output logic [2:0]          unit_code_o
);
  import ldpc_pkg::*;

  localparam int Z_FRAC_BITS = 46;
  localparam int FR_BITS     = 30;

  localparam logic signed [30:0] RAW_ONE = 31'(Q16_ONE);
  localparam logic signed [31:0] DB30    = 32'(30 * Q16_ONE);
  localparam logic signed [31:0] DB60    = 32'(60 * Q16_ONE);
  localparam logic signed [31:0] DB90    = 32'(90 * Q16_ONE);
  localparam logic signed [31:0] E_MIN   = -32'(256 * Q16_ONE);
  localparam logic signed [31:0] E_MAX   = 32'(64 * Q16_ONE);
  localparam logic signed [8:0]  Q30_TO_Q16 = 9'sd14;

  // Result fields that ride along with the power path.
  typedef struct packed {
    unit_e              unit;
    logic               use_pow;
    logic signed [31:0] direct;
  } tag_t;

  // Exponent table, built at elaboration.
  logic [31:0] pow2_rom [EXP_TABLE_DEPTH+1];
  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [31:0] ROM_ENTRY = pow2_entry(g);
    assign pow2_rom[g] = ROM_ENTRY;
  end

  // Stage valids.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s5_valid_q, s6_valid_q, s7_valid_q, done_q;

  // Stage 1: coefficient select and first Horner step.
  logic [63:0]        packed_coefs;
  logic signed [15:0] k0, k1, k2, k3;
  logic signed [12:0] xs_in;
  logic signed [28:0] p1;
  logic signed [30:0] t1_d;
  logic [ADC_W-1:0]   s1_x_q;
  logic signed [15:0] s1_k0_q, s1_k1_q;
  logic signed [30:0] s1_t1_q;

  always_comb begin
    case (item_i.seg)
      SEG_LOW:  packed_coefs = cfg_i.seg_low;
      SEG_MID:  packed_coefs = cfg_i.seg_mid;
      SEG_HIGH: packed_coefs = cfg_i.seg_high;
      default:  packed_coefs = cfg_i.seg_high;
    endcase
    k0    = signed'(packed_coefs[15:0]);
    k1    = signed'(packed_coefs[31:16]);
    k2    = signed'(packed_coefs[47:32]);
    k3    = signed'(packed_coefs[63:48]);
    xs_in = signed'({1'b0, item_i.x});
    p1    = 29'(xs_in) * 29'(k3);
    t1_d  = (31'(k2) <<< 12) + 31'(p1);
  end

  // Stage 2: second Horner step, floored to LSB 2^-32.
  logic signed [12:0] xs1;
  logic signed [43:0] p2;
  logic signed [43:0] t2;
  logic signed [31:0] t2f_d;
  logic [ADC_W-1:0]   s2_x_q;
  logic signed [15:0] s2_k0_q;
  logic signed [31:0] s2_t2_q;

  always_comb begin
    xs1   = signed'({1'b0, s1_x_q});
    p2    = 44'(xs1) * 44'(s1_t1_q);
    t2    = (44'(s1_k1_q) <<< 25) + p2;
    t2f_d = 32'(t2 >>> 12);
  end

  // Stage 3: last Horner step.
  logic signed [12:0] xs2;
  logic signed [45:0] p3;
  logic signed [45:0] t3_d;
  logic signed [45:0] s3_t3_q;

  always_comb begin
    xs2  = signed'({1'b0, s2_x_q});
    p3   = 46'(xs2) * 46'(s2_t2_q);
    t3_d = (46'(s2_k0_q) <<< 24) + p3;
  end

  // Stage 4: round to Q16, subtract the offset, overload check and unit range.
  logic signed [46:0] raw_sum;
  logic signed [30:0] raw;
  logic signed [31:0] y;
  logic signed [31:0] e;
  logic signed [31:0] e_c;
  logic               ovl;
  unit_e              unit_pw;
  tag_t               tag4_d;
  logic signed [25:0] s4_e_q;
  tag_t               s4_tag_q;

  always_comb begin
    raw_sum = 47'(s3_t3_q) + 47'sd32768;
    raw     = 31'(raw_sum >>> 16);
    y       = 32'(raw) - (32'(cfg_i.offset_db) <<< 8);
    ovl     = raw > RAW_ONE;
    if (y < -DB60) begin
      unit_pw = UNIT_PW;
      e       = y + DB90;
    end else if (y < -DB30) begin
      unit_pw = UNIT_NW;
      e       = y + DB60;
    end else if (y[31]) begin
      unit_pw = UNIT_UW;
      e       = y + DB30;
    end else if (y < DB30) begin
      unit_pw = UNIT_MW;
      e       = y;
    end else begin
      unit_pw = UNIT_W;
      e       = y - DB30;
    end
    if (e < E_MIN) begin
      e_c = E_MIN;
    end else if (e > E_MAX) begin
      e_c = E_MAX;
    end else begin
      e_c = e;
    end
    tag4_d.use_pow = !ovl && !cfg_i.dbm_mode;
    tag4_d.direct  = ovl ? OVERLOAD_Q16 : y;
    if (ovl) begin
      tag4_d.unit = UNIT_OVL;
    end else if (cfg_i.dbm_mode) begin
      tag4_d.unit = UNIT_DBM;
    end else begin
      tag4_d.unit = unit_pw;
    end
  end

  // Stage 5: convert dB to log2 at LSB 2^-46.
  logic signed [55:0] z_d;
  logic signed [55:0] s5_z_q;
  tag_t               s5_tag_q;

  assign z_d = 56'(s4_e_q) * 56'(LOG2_10_DIV10_Q30);

  // Stage 6: split log2 and read the neighboring table entries.
  logic [Z_FRAC_BITS-1:0]   frac;
  logic [EXP_IDX_BITS-1:0]  idx;
  logic [ROM_ADDR_BITS-1:0] lo_addr;
  logic [ROM_ADDR_BITS-1:0] hi_addr;
  logic [31:0]              lo_d;
  logic [31:0]              diff_d;
  logic [FR_BITS-1:0]       fr_d;
  logic signed [7:0]        n_d;
  logic [31:0]              s6_lo_q;
  logic [31:0]              s6_diff_q;
  logic [FR_BITS-1:0]       s6_fr_q;
  logic signed [7:0]        s6_n_q;
  tag_t                     s6_tag_q;

  always_comb begin
    frac    = s5_z_q[Z_FRAC_BITS-1:0];
    n_d     = 8'(s5_z_q >>> Z_FRAC_BITS);
    idx     = frac[Z_FRAC_BITS-1 -: EXP_IDX_BITS];
    fr_d    = frac[Z_FRAC_BITS-1-EXP_IDX_BITS -: FR_BITS];
    lo_addr = {1'b0, idx};
    hi_addr = lo_addr + 1'b1;
    lo_d    = pow2_rom[lo_addr];
    diff_d  = pow2_rom[hi_addr] - pow2_rom[lo_addr];
  end

  // Stage 7: linear interpolation between the table entries.
  logic [61:0]       interp;
  logic [32:0]       m_d;
  logic [32:0]       s7_m_q;
  logic signed [7:0] s7_n_q;
  tag_t              s7_tag_q;

  always_comb begin
    interp = 62'(s6_diff_q) * 62'(s6_fr_q);
    m_d    = 33'(s6_lo_q) + 33'(interp >> 30);
  end

  // Output stage: scale by 2^n with round half up and saturation.
  logic signed [8:0]  sh_amt;
  logic [40:0]        up;
  logic [7:0]         dn_amt;
  logic [32:0]        dn;
  logic [31:0]        pow_val;
  logic signed [31:0] level_d;
  logic signed [31:0] level_q;
  unit_e              unit_q;

  always_comb begin
    sh_amt = 9'(s7_n_q) - Q30_TO_Q16;
    up     = 41'(s7_m_q) << sh_amt[2:0];
    dn_amt = 8'(~sh_amt);
    dn     = s7_m_q >> dn_amt;
    if (sh_amt >= 9'sd8) begin
      pow_val = Q16_MAX;
    end else if (!sh_amt[8]) begin
      pow_val = (up > 41'(Q16_MAX)) ? Q16_MAX : up[31:0];
    end else begin
      pow_val = 32'((34'(dn) + 34'd1) >> 1);
    end
    level_d = s7_tag_q.use_pow ? signed'(pow_val) : s7_tag_q.direct;
  end

  // Valid chain; the receiver never stalls, so the pipeline always advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      done_q     <= s7_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_x_q    <= item_i.x;
    s1_k0_q   <= k0;
    s1_k1_q   <= k1;
    s1_t1_q   <= t1_d;
    s2_x_q    <= s1_x_q;
    s2_k0_q   <= s1_k0_q;
    s2_t2_q   <= t2f_d;
    s3_t3_q   <= t3_d;
    s4_e_q    <= 26'(e_c);
    s4_tag_q  <= tag4_d;
    s5_z_q    <= z_d;
    s5_tag_q  <= s4_tag_q;
    s6_lo_q   <= lo_d;
    s6_diff_q <= diff_d;
    s6_fr_q   <= fr_d;
    s6_n_q    <= n_d;
    s6_tag_q  <= s5_tag_q;
    s7_m_q    <= m_d;
    s7_n_q    <= s6_n_q;
    s7_tag_q  <= s6_tag_q;
    level_q   <= level_d;
    unit_q    <= s7_tag_q.unit;
  end

  assign done_o        = done_q;
  assign level_value_o = level_q;
  assign unit_code_o   = unit_q;

  `LDPC_ASSERT(a_latency, clk_i, rst_ni, s1_valid_q |-> ##7 done_o, "result strobe missing after pipeline latency")
  `LDPC_ASSERT(a_overload_value, clk_i, rst_ni, (done_o && unit_code_o == UNIT_OVL) |-> (level_value_o == OVERLOAD_Q16), "overload result has wrong value")

endmodule
